>>> design/stp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stp_pkg;

  localparam int PID_W = 13;
  localparam int PACKET_BYTES = 188;

  localparam logic [7:0] SYNC_BYTE   = 8'h47;
  localparam logic [7:0] PUSI_FLAG   = 8'h40;
  localparam logic [3:0] CTRL_PAYLOAD = 4'h1;
  localparam logic [7:0] STUFF_BYTE  = 8'hFF;
  localparam logic [7:0] POINTER_FIELD = 8'h00;

  // configuration register indexes
  localparam logic REG_INFO_PID = 1'b0;
  localparam logic REG_DATA_PID = 1'b1;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       sel;
  } sect_item_t;

  typedef struct packed {
    logic [31:0] word;
    logic        packet_end;
    logic        run_last;
  } ts_result_t;

endpackage

`default_nettype wire

>>> design/stp_pack.sv
`timescale 1ns / 1ps
`default_nettype none

module stp_pack import stp_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [PID_W-1:0] info_pid,
  input  wire logic [PID_W-1:0] data_pid,
  input  wire logic             item_valid,
  input  wire sect_item_t       item,
  output logic                  item_take,
  output logic                  res_valid,
  input  wire logic             res_stall,
  output ts_result_t            res
);

  localparam logic [7:0] PKT_LEN = 8'(PACKET_BYTES);

  logic [3:0]  info_cc, info_cc_next;
  logic [3:0]  data_cc, data_cc_next;
  logic [7:0]  pos, pos_next;
  logic        in_section, in_section_next;
  logic        latched_stream, latched_stream_next;
  logic [23:0] buffer, buffer_next;
  logic        stuffing, stuffing_next;

  logic             adv;
  logic             stream;
  logic             first;
  logic             open_pkt;
  logic [PID_W-1:0] pid;
  logic [3:0]       cc;
  logic [31:0]      byte_word;
  logic [7:0]       pos_inc;
  logic             byte_closes;
  logic             item_emit;
  ts_result_t       item_res;
  logic             stuff_go;
  logic [7:0]       stuff_pos;
  logic             stuff_closes;
  ts_result_t       stuff_res;
  logic             load;

  assign adv = !res_valid || !res_stall;

  always_comb begin
    stream   = in_section ? latched_stream : item.sel;
    first    = !in_section;
    open_pkt = first || (pos == 8'd0);
    pid      = stream ? data_pid : info_pid;
    cc       = stream ? data_cc : info_cc;

    byte_word   = {buffer, item.data};
    pos_inc     = pos + 8'd1;
    byte_closes = !open_pkt && (pos_inc == PKT_LEN);

    // a header always fills exactly one word; a plain byte may close one
    item_emit = open_pkt || (pos[1:0] == 2'd3);

    item_res.word = open_pkt
      ? {SYNC_BYTE, (first ? PUSI_FLAG : 8'h00) | {3'b000, pid[12:8]}, pid[7:0],
         CTRL_PAYLOAD, cc}
      : byte_word;
    item_res.packet_end = byte_closes;
    item_res.run_last   = !item.last || byte_closes;

    item_take = item_valid && !stuffing && (!item_emit || adv);
    stuff_go  = stuffing && adv;

    // stuffing pads the partial word up to the next word boundary
    stuff_pos    = {pos[7:2], 2'b00} + 8'd4;
    stuff_closes = (stuff_pos == PKT_LEN);
    case (pos[1:0])
      2'd0:    stuff_res.word = {4{STUFF_BYTE}};
      2'd1:    stuff_res.word = {buffer[7:0], {3{STUFF_BYTE}}};
      2'd2:    stuff_res.word = {buffer[15:0], {2{STUFF_BYTE}}};
      default: stuff_res.word = {buffer[23:0], STUFF_BYTE};
    endcase
    stuff_res.packet_end = stuff_closes;
    stuff_res.run_last   = stuff_closes;

    load = (item_take && item_emit) || stuff_go;

    info_cc_next        = info_cc;
    data_cc_next        = data_cc;
    pos_next            = pos;
    in_section_next     = in_section;
    latched_stream_next = latched_stream;
    buffer_next         = buffer;
    stuffing_next       = stuffing;

    if (item_take) begin
      if (open_pkt) begin
        if (stream) begin
          data_cc_next = data_cc + 4'd1;
        end else begin
          info_cc_next = info_cc + 4'd1;
        end
        if (first) begin
          buffer_next = {8'h00, POINTER_FIELD, item.data};
          pos_next    = 8'd6;
        end else begin
          buffer_next = {16'h0000, item.data};
          pos_next    = 8'd5;
        end
      end else begin
        buffer_next = (pos[1:0] == 2'd3) ? 24'h000000 : byte_word[23:0];
        pos_next    = byte_closes ? 8'd0 : pos_inc;
      end
      latched_stream_next = stream;
      in_section_next     = !item.last;
      stuffing_next       = item.last && !byte_closes;
    end else if (stuff_go) begin
      buffer_next   = 24'h000000;
      pos_next      = stuff_closes ? 8'd0 : stuff_pos;
      stuffing_next = !stuff_closes;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      info_cc        <= 4'd0;
      data_cc        <= 4'd0;
      pos            <= 8'd0;
      in_section     <= 1'b0;
      latched_stream <= 1'b0;
      buffer         <= 24'h000000;
      stuffing       <= 1'b0;
    end else begin
      info_cc        <= info_cc_next;
      data_cc        <= data_cc_next;
      pos            <= pos_next;
      in_section     <= in_section_next;
      latched_stream <= latched_stream_next;
      buffer         <= buffer_next;
      stuffing       <= stuffing_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= stuffing ? stuff_res : item_res;
    end
  end

endmodule

`default_nettype wire

>>> design/section_to_ts_packetizer.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake            Payload
// in        in_valid / in_stall  section_byte, section_last, stream_select
// out       out_valid / out_stall ts_word, packet_end, run_last
// cfg       cfg_write_en         cfg_index, cfg_data
//
// One item per cycle while the output drains; each item yields at most one
// word, except that a section's last byte is followed by 0 to 46 stuffing
// words, one per cycle, during which new items wait in the input register.
// One input register and one result register; the input register takes an
// item while a result waits. Reset clears all control and counters.

module section_to_ts_packetizer import stp_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [7:0]       section_byte,
  input  wire logic             section_last,
  input  wire logic             stream_select,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [31:0]           ts_word,
  output logic                  packet_end,
  output logic                  run_last,
  input  wire logic             cfg_write_en,
  input  wire logic             cfg_index,
  input  wire logic [PID_W-1:0] cfg_data
);

  logic [PID_W-1:0] info_pid;
  logic [PID_W-1:0] data_pid;
  logic             in_full;
  sect_item_t       in_item;
  logic             item_take;
  ts_result_t       res;

  always_ff @(posedge clk) begin
    if (rst) begin
      info_pid <= '0;
      data_pid <= '0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_INFO_PID: info_pid <= cfg_data;
        REG_DATA_PID: data_pid <= cfg_data;
        default:      info_pid <= info_pid;
      endcase
    end
  end

  assign in_stall = in_full && !item_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (item_take) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item <= '{data: section_byte, last: section_last, sel: stream_select};
    end
  end

  stp_pack u_pack (
    .clk       (clk),
    .rst       (rst),
    .info_pid  (info_pid),
    .data_pid  (data_pid),
    .item_valid(in_full),
    .item      (in_item),
    .item_take (item_take),
    .res_valid (out_valid),
    .res_stall (out_stall),
    .res       (res)
  );

  assign ts_word    = res.word;
  assign packet_end = res.packet_end;
  assign run_last   = res.run_last;

endmodule

`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import stp_pkg::*;

  localparam int DRAIN_CYCLES   = 12;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS   = 430;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       section_byte = '0;
  logic             section_last = 1'b0;
  logic             stream_select = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [31:0]      ts_word;
  logic             packet_end;
  logic             run_last;
  logic             cfg_write_en = 1'b0;
  logic             cfg_index = REG_INFO_PID;
  logic [PID_W-1:0] cfg_data = '0;

  section_to_ts_packetizer i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .section_byte  (section_byte),
    .section_last  (section_last),
    .stream_select (stream_select),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .ts_word       (ts_word),
    .packet_end    (packet_end),
    .run_last      (run_last),
    .cfg_write_en  (cfg_write_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // packetizer shadow state
  logic [PID_W-1:0] info_pid_q, data_pid_q;
  logic [3:0]       info_cc, data_cc;
  logic [7:0]       pkt_fill;
  logic             sect_open, sect_stream;
  logic [23:0]      pend_bytes;
  logic [1:0]       pend_cnt;

  ts_result_t words_due[$];
  sect_item_t bytes_pending[$];

  int  items_queued = 0;
  int  items_taken = 0;
  int  rand_items = 0;
  int  errors = 0;
  int  quiet_cycles = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  int  hold_left = 0;
  bit  in_taken = 1'b0;
  bit  snd_gaps = 1'b1;
  bit  rcv_stalls = 1'b1;
  bit  hold_req = 1'b0;
  sect_item_t nxt_item;

  task automatic emit_packet_byte(input logic [7:0] b);
    logic [31:0] word;
    logic        closes;
    pkt_fill = pkt_fill + 8'd1;
    closes = (pkt_fill >= PACKET_BYTES);
    word = {pend_bytes, b};
    pend_cnt = pend_cnt + 2'd1;
    if (pend_cnt == 2'd0) begin
      words_due.push_back(ts_result_t'({word, closes, 1'b0}));
      pend_bytes = '0;
    end else begin
      pend_bytes = word[23:0];
    end
    if (closes) pkt_fill = '0;
  endtask

  task automatic open_ts_packet(input logic first);
    logic [PID_W-1:0] pid;
    logic [3:0]       cc;
    pid = sect_stream ? data_pid_q : info_pid_q;
    if (sect_stream) begin
      cc = data_cc;
      data_cc = data_cc + 4'd1;
    end else begin
      cc = info_cc;
      info_cc = info_cc + 4'd1;
    end
    emit_packet_byte(SYNC_BYTE);
    emit_packet_byte((first ? PUSI_FLAG : 8'h00) | {3'b000, pid[12:8]});
    emit_packet_byte(pid[7:0]);
    emit_packet_byte({CTRL_PAYLOAD, cc});
    if (first) emit_packet_byte(POINTER_FIELD);
  endtask

  task automatic pack_section_byte(input logic [7:0] b, input logic last, input logic sel);
    ts_result_t w;
    int         n_before;
    n_before = words_due.size();
    if (!sect_open) begin
      sect_stream = sel;
      sect_open = 1'b1;
      open_ts_packet(1'b1);
    end else if (pkt_fill == 8'd0) begin
      open_ts_packet(1'b0);
    end
    emit_packet_byte(b);
    if (last) begin
      while (pkt_fill != 8'd0) emit_packet_byte(STUFF_BYTE);
      sect_open = 1'b0;
    end
    if (words_due.size() > n_before) begin
      w = words_due.pop_back();
      w.run_last = 1'b1;
      words_due.push_back(w);
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // checker and shadow model, both on the rising edge
  always @(posedge clk) begin
    ts_result_t seen, want;
    bit         moved;
    if (rst) begin
      info_pid_q = '0;
      data_pid_q = '0;
      info_cc = '0;
      data_cc = '0;
      pkt_fill = '0;
      sect_open = 1'b0;
      sect_stream = 1'b0;
      pend_bytes = '0;
      pend_cnt = '0;
      words_due.delete();
    end else begin
      moved = 1'b0;
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        seen = ts_result_t'({ts_word, packet_end, run_last});
        if (words_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected word %h end=%b last=%b", $time, ts_word, packet_end,
                   run_last);
        end else begin
          want = words_due.pop_front();
          if (seen.word !== want.word || seen.packet_end !== want.packet_end ||
              seen.run_last !== want.run_last) begin
            errors++;
            $display("%0t: mismatch expected word=%h end=%b last=%b, got word=%h end=%b last=%b",
                     $time, want.word, want.packet_end, want.run_last,
                     seen.word, seen.packet_end, seen.run_last);
          end
        end
      end
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        in_taken = 1'b1;
        items_taken++;
        pack_section_byte(section_byte, section_last, stream_select);
      end
      if (cfg_write_en) begin
        if (cfg_index == REG_INFO_PID) info_pid_q = cfg_data;
        else data_pid_q = cfg_data;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
    end
  end

  // section byte sender
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      in_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (bytes_pending.size() != 0) begin
        nxt_item = bytes_pending.pop_front();
        section_byte <= nxt_item.data;
        section_last <= nxt_item.last;
        stream_select <= nxt_item.sel;
        in_valid <= 1'b1;
        gap_left = snd_gaps ? pick_gap() : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // word receiver
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (rcv_stalls) stall_left = pick_gap();
    end
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(negedge clk);
    $display("** section_to_ts_packetizer: FAILED **");
    $finish;
  end

  task automatic set_pid(input logic idx, input logic [PID_W-1:0] v);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [PID_W-1:0] pick_pid();
    int r;
    r = $urandom_range(0, 3);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return PID_W'($urandom_range(0, 8191));
  endfunction

  task automatic queue_item(input logic [7:0] d, input logic last, input logic sel);
    bytes_pending.push_back(sect_item_t'({d, last, sel}));
    items_queued++;
  endtask

  task automatic queue_run(input int n, input bit ends);
    for (int i = 0; i < n; i++)
      queue_item(8'($urandom_range(0, 255)), ends && (i == n - 1), 1'($urandom_range(0, 1)));
  endtask

  // whole sections, mostly short
  task automatic queue_sections(input int budget);
    int added;
    int r;
    int len;
    added = 0;
    while (added < budget) begin
      r = $urandom_range(0, 99);
      if (r < 45) len = 1;
      else if (r < 85) len = $urandom_range(2, 8);
      else len = $urandom_range(9, 30);
      queue_run(len, 1'b1);
      added += len;
      rand_items += len;
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (items_taken != items_queued || words_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_pid(REG_INFO_PID, '1);
    set_pid(REG_DATA_PID, '0);
    queue_item(8'h00, 1'b1, 1'b0);
    queue_item(8'hFF, 1'b1, 1'b1);
    // stream select flips inside the section and must be ignored
    queue_item(8'hAA, 1'b0, 1'b1);
    queue_item(8'h55, 1'b0, 1'b0);
    queue_item(8'h0F, 1'b1, 1'b1);
    queue_item(8'h80, 1'b0, 1'b0);
    queue_item(8'h01, 1'b0, 1'b1);
    queue_item(8'h7F, 1'b0, 1'b1);
    queue_item(8'hFE, 1'b1, 1'b0);
    // enough packets on the info stream to wrap its continuity counter
    for (int i = 0; i < 16; i++) queue_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
    wait_drained();

    // receiver holds off while sender keeps offering
    set_pid(REG_INFO_PID, '0);
    set_pid(REG_DATA_PID, '1);
    snd_gaps = 1'b0;
    hold_req = 1'b1;
    queue_sections(40);
    wait_drained();

    // first packet exactly full, then PID change before the continuation packet,
    // which is itself filled exactly by the last byte
    rcv_stalls = 1'b0;
    queue_run(183, 1'b0);
    rand_items += 183;
    wait_drained();
    set_pid(REG_INFO_PID, pick_pid());
    set_pid(REG_DATA_PID, pick_pid());
    snd_gaps = 1'b1;
    rcv_stalls = 1'b1;
    queue_run(184, 1'b1);
    rand_items += 184;
    wait_drained();

    while (rand_items < RANDOM_ITEMS) begin
      set_pid(REG_INFO_PID, pick_pid());
      set_pid(REG_DATA_PID, pick_pid());
      snd_gaps = 1'($urandom_range(0, 1));
      rcv_stalls = 1'($urandom_range(0, 1));
      queue_sections(12);
      wait_drained();
    end

    if (errors == 0)
      $display("** section_to_ts_packetizer: PASSED **");
    else
      $display("** section_to_ts_packetizer: FAILED **");
    $finish;
  end

endmodule

>>> sim.f
design/stp_pkg.sv
design/stp_pack.sv
design/section_to_ts_packetizer.sv
sim/tb.sv
